>>> sv/dmn_pkg.sv
`timescale 1ns / 1ps

package dmn_pkg;

    // Field types of one input beat and one result beat
    typedef logic [1:0] opcode_t;
    typedef logic [1:0] kind_t;
    typedef logic [3:0] node_id_t;
    typedef logic [4:0] node_count_t;

    // Input opcodes
    localparam opcode_t OP_TICK = 2'd0;
    localparam opcode_t OP_REQUEST = 2'd1;
    localparam opcode_t OP_PERMIT = 2'd2;

    // Result kinds
    localparam kind_t K_ACK = 2'd0;
    localparam kind_t K_REQ = 2'd1;
    localparam kind_t K_GRANT = 2'd2;
    localparam kind_t K_ENTER = 2'd3;

    // Configuration register indexes
    localparam logic REG_OWN_ID = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    // Configuration reset values
    localparam node_id_t OWN_ID_RESET = 4'd0;
    localparam node_count_t NODE_COUNT_RESET = 5'd4;

    // Hard ceiling on peer slots set by the 4-bit identifier fields
    localparam int ID_SLOTS = 16;

endpackage

>>> sv/distributed_mutex_node.sv
`timescale 1ns / 1ps

// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+-------------------------------
// command   | start, busy, opcode, peer_id, peer_time   | beat taken when start && !busy
// result    | result_valid, kind, dest_node,            | one-cycle strobe, no stall
//           | clock_value, last                         |
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | beat taken when valid && ready
//
// Every beat runs on a sequencer around one shared clock-update unit
// (max(clock, operand) + 1); busy stays high until the beat is done. A permission
// sets a permit bit, a request is acked and, unless deferred, granted; a released tick
// broadcasts requests; a full-permit wanted tick enters; one table pass per grant.
// Asynchronous reset clears mode, clock, stamp, permissions and deferred valid bits.
// Results cannot be stalled: each one shows for exactly one cycle.

module distributed_mutex_node #(
    parameter int MAX_NODES = 16,
    parameter int CLOCK_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  start,
    output logic                  busy,
    input  dmn_pkg::opcode_t      opcode,
    input  dmn_pkg::node_id_t     peer_id,
    input  logic [31:0]           peer_time,

    output logic                  result_valid,
    output dmn_pkg::kind_t        kind,
    output dmn_pkg::node_id_t     dest_node,
    output logic [31:0]           clock_value,
    output logic                  last,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [4:0]            cfg_data
);

    localparam int SLOTS = (MAX_NODES < dmn_pkg::ID_SLOTS) ? MAX_NODES : dmn_pkg::ID_SLOTS;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = CLOCK_BITS;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TICK = 3'd1;
    localparam logic [2:0] ST_BCAST = 3'd2;
    localparam logic [2:0] ST_REQS = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_GRANT = 3'd5;
    localparam logic [2:0] ST_RQ_ACK = 3'd6;
    localparam logic [2:0] ST_RQ_GRANT = 3'd7;

    logic [2:0]                state_reg, state_next;
    logic                      perm_pend_reg, perm_pend_next;
    logic                      mode_reg, mode_next;
    logic [CW-1:0]             clock_reg, clock_next;
    logic [CW-1:0]             stamp_reg, stamp_next;
    logic [SLOTS-1:0]          perm_reg, perm_next;
    logic [SLOTS-1:0]          dvalid_reg, dvalid_next;
    dmn_pkg::node_id_t         own_id_reg, own_id_next;
    dmn_pkg::node_count_t      ncount_reg, ncount_next;
    logic [SW-1:0]             idx_reg, idx_next;
    logic [SW-1:0]             best_reg, best_next;
    logic [CW-1:0]             best_stamp_reg, best_stamp_next;
    logic                      found_reg, found_next;
    logic                      defer_reg, defer_next;

    // Captured command payload
    dmn_pkg::node_id_t         pid_reg;
    logic [CW-1:0]             ptime_reg;

    // Deferred request stamps
    logic [CW-1:0]             dstamp_reg [SLOTS];
    logic                      dstamp_we;

    // Result register
    logic                      rvalid_reg, rvalid_next;
    dmn_pkg::kind_t            kind_reg, kind_next;
    dmn_pkg::node_id_t         dest_reg, dest_next;
    logic [31:0]               cval_reg, cval_next;
    logic                      last_reg, last_next;

    // Shared clock-update unit
    logic                      bump_use_peer;
    logic [CW-1:0]             bump_b;
    logic [CW-1:0]             bump_out;

    logic                      accept;
    dmn_pkg::node_count_t      n_eff;
    logic [SLOTS-1:0]          peer_mask;
    logic                      all_permits;
    logic                      id_ok;
    logic [CW-1:0]             t_in;
    logic                      later;
    logic [4:0]                idx_ext;
    logic [4:0]                own_ext;
    logic [4:0]                nxt_ext;
    logic                      more_reqs;
    logic                      scan_take;
    logic [SLOTS-1:0]          best_onehot;
    logic [SW-1:0]             pid_slot;

    assign busy = (state_reg != ST_IDLE) || perm_pend_reg;
    assign accept = start && !busy;
    assign cfg_ready = !busy;

    // Clamp the node count to the slot range; zero counts as one
    always_comb
    begin
        if (ncount_reg > 5'(SLOTS))
        begin
            n_eff = 5'(SLOTS);
        end
        else if (ncount_reg == 5'd0)
        begin
            n_eff = 5'd1;
        end
        else
        begin
            n_eff = ncount_reg;
        end
    end

    assign own_ext = 5'(own_id_reg);

    // Mark slots that belong to peers
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            peer_mask[i] = (5'(i) < n_eff) && (5'(i) != own_ext);
        end
    end

    assign all_permits = &(perm_reg | ~peer_mask);

    // Check the sender and order it against our own request
    assign id_ok = (5'(peer_id) < n_eff) && (peer_id != own_id_reg);
    assign t_in = CW'(peer_time);
    assign later = (t_in > stamp_reg) || ((t_in == stamp_reg) && (peer_id > own_id_reg));
    assign pid_slot = pid_reg[SW-1:0];

    // Shared unit: clock = max(clock, operand) + 1
    assign bump_b = bump_use_peer ? ptime_reg : clock_reg;
    assign bump_out = ((bump_b > clock_reg) ? bump_b : clock_reg) + CW'(1);

    // Look ahead for another peer in the broadcast
    assign idx_ext = 5'(idx_reg);
    assign nxt_ext = idx_ext + 5'd1;
    assign more_reqs = (nxt_ext < n_eff) && !((nxt_ext == own_ext) && (nxt_ext + 5'd1 >= n_eff));

    // Minimum search over the deferred table, one slot per cycle
    assign scan_take = dvalid_reg[idx_reg] && (!found_reg || (dstamp_reg[idx_reg] < best_stamp_reg));

    always_comb
    begin
        best_onehot = '0;
        best_onehot[best_reg] = 1'b1;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        perm_pend_next = 1'b0;
        mode_next = mode_reg;
        clock_next = clock_reg;
        stamp_next = stamp_reg;
        perm_next = perm_reg;
        dvalid_next = dvalid_reg;
        own_id_next = own_id_reg;
        ncount_next = ncount_reg;
        idx_next = idx_reg;
        best_next = best_reg;
        best_stamp_next = best_stamp_reg;
        found_next = found_reg;
        defer_next = defer_reg;
        dstamp_we = 1'b0;
        bump_use_peer = 1'b0;
        rvalid_next = 1'b0;
        kind_next = kind_reg;
        dest_next = dest_reg;
        cval_next = cval_reg;
        last_next = last_reg;

        // Take configuration beats
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dmn_pkg::REG_OWN_ID:     own_id_next = cfg_data[3:0];
                dmn_pkg::REG_NODE_COUNT: ncount_next = cfg_data;
                default:                 ncount_next = ncount_reg;
            endcase
        end

        // Apply a peer permission
        if (perm_pend_reg)
        begin
            bump_use_peer = 1'b1;
            clock_next = bump_out;
            perm_next[pid_slot] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    defer_next = mode_reg && later;
                    priority if (opcode == dmn_pkg::OP_TICK)
                    begin
                        state_next = ST_TICK;
                    end
                    else if (opcode == dmn_pkg::OP_REQUEST && id_ok)
                    begin
                        state_next = ST_RQ_ACK;
                    end
                    else if (opcode == dmn_pkg::OP_PERMIT && id_ok)
                    begin
                        perm_pend_next = 1'b1;
                    end
                end
            end

            ST_TICK:
            begin
                clock_next = bump_out;
                if (!mode_reg)
                begin
                    mode_next = 1'b1;
                    stamp_next = bump_out;
                    perm_next = '0;
                    state_next = ST_BCAST;
                end
                else if (all_permits)
                begin
                    perm_next = '0;
                    mode_next = 1'b0;
                    rvalid_next = 1'b1;
                    kind_next = dmn_pkg::K_ENTER;
                    dest_next = own_id_reg;
                    cval_next = 32'(bump_out);
                    last_next = (dvalid_reg == '0);
                    idx_next = '0;
                    found_next = 1'b0;
                    state_next = (dvalid_reg == '0) ? ST_IDLE : ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_BCAST:
            begin
                clock_next = bump_out;
                idx_next = '0;
                state_next = ST_REQS;
            end

            ST_REQS:
            begin
                if (idx_ext != own_ext)
                begin
                    rvalid_next = 1'b1;
                    kind_next = dmn_pkg::K_REQ;
                    dest_next = 4'(idx_reg);
                    cval_next = 32'(clock_reg);
                    last_next = !more_reqs;
                end
                idx_next = idx_reg + SW'(1);
                // Leave as soon as no peer is left to ask
                if (!more_reqs)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (scan_take)
                begin
                    best_next = idx_reg;
                    best_stamp_next = dstamp_reg[idx_reg];
                    found_next = 1'b1;
                end
                idx_next = idx_reg + SW'(1);
                if (idx_reg == SW'(SLOTS - 1))
                begin
                    state_next = ST_GRANT;
                end
            end

            ST_GRANT:
            begin
                clock_next = bump_out;
                dvalid_next = dvalid_reg & ~best_onehot;
                rvalid_next = 1'b1;
                kind_next = dmn_pkg::K_GRANT;
                dest_next = 4'(best_reg);
                cval_next = 32'(bump_out);
                last_next = ((dvalid_reg & ~best_onehot) == '0);
                idx_next = '0;
                found_next = 1'b0;
                state_next = ((dvalid_reg & ~best_onehot) == '0) ? ST_IDLE : ST_SCAN;
            end

            ST_RQ_ACK:
            begin
                bump_use_peer = 1'b1;
                clock_next = bump_out;
                rvalid_next = 1'b1;
                kind_next = dmn_pkg::K_ACK;
                dest_next = pid_reg;
                cval_next = 32'(bump_out);
                last_next = defer_reg;
                if (defer_reg)
                begin
                    dstamp_we = 1'b1;
                    dvalid_next[pid_slot] = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RQ_GRANT;
                end
            end

            ST_RQ_GRANT:
            begin
                bump_use_peer = 1'b1;
                clock_next = bump_out;
                rvalid_next = 1'b1;
                kind_next = dmn_pkg::K_GRANT;
                dest_next = pid_reg;
                cval_next = 32'(bump_out);
                last_next = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            perm_pend_reg <= 1'b0;
            mode_reg <= 1'b0;
            clock_reg <= '0;
            stamp_reg <= '0;
            perm_reg <= '0;
            dvalid_reg <= '0;
            own_id_reg <= dmn_pkg::OWN_ID_RESET;
            ncount_reg <= dmn_pkg::NODE_COUNT_RESET;
            idx_reg <= '0;
            best_reg <= '0;
            found_reg <= 1'b0;
            defer_reg <= 1'b0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            perm_pend_reg <= perm_pend_next;
            mode_reg <= mode_next;
            clock_reg <= clock_next;
            stamp_reg <= stamp_next;
            perm_reg <= perm_next;
            dvalid_reg <= dvalid_next;
            own_id_reg <= own_id_next;
            ncount_reg <= ncount_next;
            idx_reg <= idx_next;
            best_reg <= best_next;
            found_reg <= found_next;
            defer_reg <= defer_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Hold payload: captured beat, best stamp, deferred stamps, result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pid_reg <= peer_id;
            ptime_reg <= t_in;
        end
        best_stamp_reg <= best_stamp_next;
        if (dstamp_we)
        begin
            dstamp_reg[pid_slot] <= ptime_reg;
        end
        kind_reg <= kind_next;
        dest_reg <= dest_next;
        cval_reg <= cval_next;
        last_reg <= last_next;
    end

    assign result_valid = rvalid_reg;
    assign kind = kind_reg;
    assign dest_node = dest_reg;
    assign clock_value = cval_reg;
    assign last = last_reg;

`ifndef ASSERT_OFF
    // The final result of a beat leaves the block free for the next one
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("busy still high after final result");

    // A result follows only from work in progress
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a beat in progress");

    // A grant goes only to a slot that is still deferred
    a_grant_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GRANT) |-> dvalid_reg[best_reg])
        else $error("grant to a slot with no deferred request");

    // Wanted mode is entered only by a tick
    a_wanted_by_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mode_reg) |-> ($past(state_reg) == ST_TICK))
        else $error("mode changed to wanted outside a tick");

    // Deferred slots are added only while acknowledging a request
    a_defer_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
        ((dvalid_reg & ~$past(dvalid_reg)) != '0) |-> ($past(state_reg) == ST_RQ_ACK))
        else $error("deferred slot set outside request handling");
`endif

endmodule
